// ===== rtl/core/knv_pkg.sv =====
// Shared types and constants for the k nearest value sum block.
package knv_pkg;

  localparam int unsigned MAX_NEAREST_DEF = 16;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIST_W  = 33;
  localparam int unsigned SQ_W    = 32;
  localparam int unsigned VAL_W   = 24;
  localparam int unsigned SUM_W   = 28;
  localparam int unsigned K_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAREST_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT,
    OP_CLEAR
  } knv_op_e;

  typedef enum logic {
    KNV_RUN,
    KNV_DRAIN
  } knv_state_e;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] distance;
    logic [VAL_W-1:0]  value;
  } knv_entry_t;

  typedef struct packed {
    knv_op_e           op;
    logic [DIST_W-1:0] distance;
    logic [VAL_W-1:0]  value;
  } knv_ctrl_t;

endpackage

// ===== rtl/core/knv_dist.sv =====
// Squared distance stage: registered squares of the offsets from the origin.
module knv_dist (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic signed [knv_pkg::COORD_W-1:0] x_i,
  input  logic signed [knv_pkg::COORD_W-1:0] y_i,
  input  logic        [knv_pkg::VAL_W-1:0]   value_i,
  input  logic                              last_i,
  input  logic signed [knv_pkg::COORD_W-1:0] origin_x_i,
  input  logic signed [knv_pkg::COORD_W-1:0] origin_y_i,
  output logic                              valid_o,
  output logic        [knv_pkg::DIST_W-1:0]  dist_o,
  output logic        [knv_pkg::VAL_W-1:0]   value_o,
  output logic                              last_o
);

  logic signed [knv_pkg::COORD_W:0]     dx, dy;
  logic signed [2*knv_pkg::COORD_W+1:0] prod_x, prod_y;
  logic [knv_pkg::SQ_W-1:0]             sqx_q, sqy_q;
  logic [knv_pkg::VAL_W-1:0]            value_q;
  logic                                 last_q;
  logic                                 valid_q;

  always_comb begin
    dx     = $signed({x_i[knv_pkg::COORD_W-1], x_i})
           - $signed({origin_x_i[knv_pkg::COORD_W-1], origin_x_i});
    dy     = $signed({y_i[knv_pkg::COORD_W-1], y_i})
           - $signed({origin_y_i[knv_pkg::COORD_W-1], origin_y_i});
    prod_x = dx * dx;
    prod_y = dy * dy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      // a square of a 17-bit offset always fits in 32 bits
      sqx_q   <= prod_x[knv_pkg::SQ_W-1:0];
      sqy_q   <= prod_y[knv_pkg::SQ_W-1:0];
      value_q <= value_i;
      last_q  <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign dist_o  = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign value_o = value_q;
  assign last_o  = last_q;

endmodule

// ===== rtl/core/knv_cell.sv =====
// One cell of the sorted chain: holds one entry, inserts, shifts or clears.
module knv_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  knv_pkg::knv_ctrl_t  ctrl_i,
  input  logic                prev_keep_i,
  input  knv_pkg::knv_entry_t prev_i,
  input  knv_pkg::knv_entry_t next_i,
  output knv_pkg::knv_entry_t ent_o,
  output logic                keep_o
);

  logic                       valid_q, valid_d;
  logic [knv_pkg::DIST_W-1:0] dist_q, dist_d;
  logic [knv_pkg::VAL_W-1:0]  value_q, value_d;

  always_comb begin
    // ties stay put, so a new point lands after equal distances
    keep_o  = valid_q && (dist_q <= ctrl_i.distance);
    valid_d = valid_q;
    dist_d  = dist_q;
    value_d = value_q;
    unique case (ctrl_i.op)
      knv_pkg::OP_HOLD: begin
      end
      knv_pkg::OP_INSERT: begin
        if (!keep_o) begin
          if (prev_keep_i) begin
            valid_d = 1'b1;
            dist_d  = ctrl_i.distance;
            value_d = ctrl_i.value;
          end else begin
            valid_d = prev_i.valid;
            dist_d  = prev_i.distance;
            value_d = prev_i.value;
          end
        end
      end
      knv_pkg::OP_SHIFT: begin
        valid_d = next_i.valid;
        dist_d  = next_i.distance;
        value_d = next_i.value;
      end
      knv_pkg::OP_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q  <= dist_d;
    value_q <= value_d;
  end

  assign ent_o = '{valid: valid_q, distance: dist_q, value: value_q};

endmodule

// ===== rtl/core/k_nearest_value_sum.sv =====
// Top level: origin registers, distance stage, sorted cell chain and drain adder.
//
// Keeps the nearest MaxNearest points to the configured origin in a chain of
// cells sorted by squared distance, equal distances in arrival order. A point
// that is not marked last is taken every cycle: the distance stage registers
// its squared offsets, and the chain inserts it in the cycle after. A point
// marked last blocks the input while it is inserted and the chain then shifts
// its entries one a cycle into the adder; the next point is taken once the
// sum is written to the output register, where the result waits; points of
// the next set are taken meanwhile. The list is empty after the result.
module k_nearest_value_sum #(
  parameter int unsigned MaxNearest = knv_pkg::MAX_NEAREST_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [knv_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [knv_pkg::COORD_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [knv_pkg::COORD_W-1:0]   x_coord_i,
  input  logic signed [knv_pkg::COORD_W-1:0]   y_coord_i,
  input  logic        [knv_pkg::VAL_W-1:0]     item_value_i,
  input  logic                                last_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic        [knv_pkg::SUM_W-1:0]     value_sum_o,
  output logic        [knv_pkg::K_W-1:0]       items_summed_o
);

  localparam int unsigned CntW = $clog2(MaxNearest + 1);
  localparam int unsigned KW   = (CntW > knv_pkg::K_W) ? CntW : knv_pkg::K_W;
  localparam int unsigned AccW = knv_pkg::VAL_W + CntW;
  localparam int unsigned SatW = (AccW > knv_pkg::SUM_W) ? AccW : knv_pkg::SUM_W;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxNearest);

  // configuration
  logic signed [knv_pkg::COORD_W-1:0] origin_x_q, origin_y_q;
  logic [knv_pkg::K_W-1:0]            nearest_count_q;

  // distance stage
  logic                         s1_valid, s1_last;
  logic [knv_pkg::DIST_W-1:0]   s1_dist;
  logic [knv_pkg::VAL_W-1:0]    s1_value;

  // chain
  knv_pkg::knv_ctrl_t  ctrl;
  knv_pkg::knv_entry_t ent   [MaxNearest];
  logic                keep  [MaxNearest];
  logic [MaxNearest-1:0] valid_vec;

  // control
  knv_pkg::knv_state_e state_q, state_d;
  logic [CntW-1:0] filled_q, filled_d, filled_inc;
  logic [KW-1:0]   k_q, k_d, cnt_q, cnt_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            out_valid_q, out_valid_d;
  logic [knv_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [knv_pkg::K_W-1:0]   items_q, items_d;
  logic [SatW-1:0] acc_ext;
  logic            in_fire, out_free;

  assign in_ready_o = (state_q == knv_pkg::KNV_RUN) && !(s1_valid && s1_last);
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q      <= '0;
      origin_y_q      <= '0;
      nearest_count_q <= knv_pkg::K_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        knv_pkg::CFG_ORIGIN_X:      origin_x_q <= cfg_data_i;
        knv_pkg::CFG_ORIGIN_Y:      origin_y_q <= cfg_data_i;
        knv_pkg::CFG_NEAREST_COUNT: nearest_count_q <= cfg_data_i[knv_pkg::K_W-1:0];
        default: begin
        end
      endcase
    end
  end

  knv_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_fire),
    .x_i        (x_coord_i),
    .y_i        (y_coord_i),
    .value_i    (item_value_i),
    .last_i     (last_item_i),
    .origin_x_i (origin_x_q),
    .origin_y_i (origin_y_q),
    .valid_o    (s1_valid),
    .dist_o     (s1_dist),
    .value_o    (s1_value),
    .last_o     (s1_last)
  );

  for (genvar i = 0; i < MaxNearest; i++) begin : g_cell
    knv_pkg::knv_entry_t prev_ent, next_ent;
    logic                prev_keep;
    if (i == 0) begin : g_head
      assign prev_ent  = '0;
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_ent  = ent[i-1];
      assign prev_keep = keep[i-1];
    end
    if (i == MaxNearest - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_link
      assign next_ent = ent[i+1];
    end
    knv_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_keep_i (prev_keep),
      .prev_i      (prev_ent),
      .next_i      (next_ent),
      .ent_o       (ent[i]),
      .keep_o      (keep[i])
    );
    assign valid_vec[i] = ent[i].valid;
  end

  assign filled_inc = (filled_q < MaxCnt) ? filled_q + CntW'(1) : filled_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign acc_ext    = SatW'(acc_q);

  always_comb begin
    state_d       = state_q;
    filled_d      = filled_q;
    k_d           = k_q;
    cnt_d         = cnt_q;
    acc_d         = acc_q;
    sum_d         = sum_q;
    items_d       = items_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    ctrl.op       = knv_pkg::OP_HOLD;
    ctrl.distance = s1_dist;
    ctrl.value    = s1_value;
    unique case (state_q)
      knv_pkg::KNV_RUN: begin
        if (s1_valid) begin
          ctrl.op  = knv_pkg::OP_INSERT;
          filled_d = filled_inc;
          if (s1_last) begin
            // sum only what the list holds
            k_d     = (KW'(nearest_count_q) < KW'(filled_inc)) ?
                      KW'(nearest_count_q) : KW'(filled_inc);
            cnt_d   = '0;
            acc_d   = '0;
            state_d = knv_pkg::KNV_DRAIN;
          end
        end
      end
      knv_pkg::KNV_DRAIN: begin
        if (cnt_q != k_q) begin
          // advance the chain towards the head, one entry into the adder
          ctrl.op = knv_pkg::OP_SHIFT;
          acc_d   = acc_q + AccW'(ent[0].value);
          cnt_d   = cnt_q + KW'(1);
        end else if (out_free) begin
          ctrl.op     = knv_pkg::OP_CLEAR;
          filled_d    = '0;
          sum_d       = (acc_ext > SatW'(knv_pkg::SUM_MAX)) ?
                        knv_pkg::SUM_MAX : acc_ext[knv_pkg::SUM_W-1:0];
          items_d     = k_q[knv_pkg::K_W-1:0];
          out_valid_d = 1'b1;
          state_d     = knv_pkg::KNV_RUN;
        end
      end
      default: begin
        state_d = knv_pkg::KNV_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= knv_pkg::KNV_RUN;
      filled_q    <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      filled_q    <= filled_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    sum_q   <= sum_d;
    items_q <= items_d;
  end

  assign out_valid_o    = out_valid_q;
  assign value_sum_o    = sum_q;
  assign items_summed_o = items_q;

`ifndef SYNTHESIS
  // the drain shifts entries out ahead of the count, so compare only while running
  a_filled_matches_cells : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == knv_pkg::KNV_RUN) |-> ($countones(valid_vec) == int'(filled_q)))
    else $error("fill count disagrees with valid cells");

  a_no_accept_in_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == knv_pkg::KNV_DRAIN) |-> !in_ready_o)
    else $error("input taken while draining");

  a_clear_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == knv_pkg::KNV_DRAIN && cnt_q == k_q && out_free) |=>
      (valid_vec == '0 && out_valid_o))
    else $error("list not cleared or result lost");

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == knv_pkg::KNV_DRAIN) |-> (cnt_q <= k_q && k_q <= KW'(filled_q)))
    else $error("drain count beyond list");
`endif

endmodule
